### sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("%m: check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

### sv/bda_pkg.sv
package bda_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MUL_H, ST_MUL_K, ST_STEP, ST_DIV_T, ST_MUL_TH, ST_MUL_TK,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_CMP, ST_DONE
  } state_t;

  // Shared unit operation selects
  typedef enum logic [1:0] {
    OP_NONE, OP_DIV, OP_MUL
  } op_t;
endpackage

### sv/bounded_denominator_approximation.sv
// Channel | ports                                         | dir
// input   | start, busy, in_target_num/den, in_den_limit  | in (busy is out)
// result  | out_valid, out_best_num/den, out_bad_input    | out
// One item at a time. Trivial cases go straight to the result; otherwise each
// continued-fraction step runs a divide and two multiplies on the shared
// unit (W = 64 bits); a walk that passes the bound then runs one divide and two
// multiplies when a semiconvergent is possible, and six multiplies to compare.
// rst_n is synchronous; the result strobe lasts one cycle and cannot stall.
`include "assert_macros.svh"
module bounded_denominator_approximation #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_target_num,
  input  logic [31:0] in_target_den,
  input  logic [31:0] in_den_limit,
  output logic        out_valid,
  output logic [31:0] out_best_num,
  output logic [31:0] out_best_den,
  output logic        out_bad_input
);
  localparam int W = 64;

  bda_pkg::state_t st_r, st_nxt;
  bda_pkg::op_t    op;
  logic [W-1:0] ua, ub, lo, hi;
  logic         ubusy, udone;
  logic [W-1:0] p_r, q_r, lim_r, x_r, y_r, h0_r, h1_r, k0_r, k1_r;
  logic [W-1:0] a_r, r_r, h_r, t_r, ch_r, ck_r, ec_r, ep_r;
  logic [W-1:0] m1_r, m2_r, c1h_r, c1l_r;
  logic [W-1:0] rn_r, rd_r;
  logic         bad_r, vld_r;
  logic [W-1:0] p_in, q_in, l_in, dif;
  logic [W-1:0] m_mask;
  logic [W-1:0] k_new;
  logic         accept;
  logic         trivial;

  assign m_mask = (WIDTH >= 32) ? W'(32'hFFFF_FFFF) : ((W'(1) << WIDTH) - W'(1));
  assign p_in = W'(in_target_num) & m_mask;
  assign q_in = W'(in_target_den) & m_mask;
  assign l_in = W'(in_den_limit) & m_mask;
  assign dif  = (m1_r >= m2_r) ? m1_r - m2_r : m2_r - m1_r;
  assign k_new   = lo + k0_r;
  assign accept  = start && !busy;
  assign trivial = (q_in == '0) || (l_in == '0) || (q_in <= l_in);

  bda_unit #(.W(W)) u_unit (
    .clk, .rst_n, .op, .a(ua), .b(ub), .busy(ubusy), .done(udone),
    .res_lo(lo), .res_hi(hi)
  );

  // Unit operand selection
  always_comb begin
    op = bda_pkg::OP_NONE;
    ua = '0;
    ub = '0;
    if (!ubusy && !udone) begin
      unique case (st_r)
        bda_pkg::ST_DIV:    begin op = bda_pkg::OP_DIV; ua = x_r; ub = y_r; end
        bda_pkg::ST_MUL_H:  begin op = bda_pkg::OP_MUL; ua = a_r; ub = h1_r; end
        bda_pkg::ST_MUL_K:  begin op = bda_pkg::OP_MUL; ua = a_r; ub = k1_r; end
        bda_pkg::ST_DIV_T:  begin op = bda_pkg::OP_DIV; ua = lim_r - k0_r; ub = k1_r; end
        bda_pkg::ST_MUL_TH: begin op = bda_pkg::OP_MUL; ua = t_r; ub = h1_r; end
        bda_pkg::ST_MUL_TK: begin op = bda_pkg::OP_MUL; ua = t_r; ub = k1_r; end
        bda_pkg::ST_M1:     begin op = bda_pkg::OP_MUL; ua = ch_r; ub = q_r; end
        bda_pkg::ST_M2:     begin op = bda_pkg::OP_MUL; ua = ck_r; ub = p_r; end
        bda_pkg::ST_M3:     begin op = bda_pkg::OP_MUL; ua = h1_r; ub = q_r; end
        bda_pkg::ST_M4:     begin op = bda_pkg::OP_MUL; ua = k1_r; ub = p_r; end
        bda_pkg::ST_M5:     begin op = bda_pkg::OP_MUL; ua = ec_r; ub = k1_r; end
        bda_pkg::ST_M6:     begin op = bda_pkg::OP_MUL; ua = ep_r; ub = ck_r; end
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bda_pkg::ST_IDLE: if (accept) begin
        st_nxt = trivial ? bda_pkg::ST_DONE : bda_pkg::ST_DIV;
      end
      bda_pkg::ST_DIV:    if (udone) st_nxt = bda_pkg::ST_MUL_H;
      bda_pkg::ST_MUL_H:  if (udone) st_nxt = bda_pkg::ST_MUL_K;
      bda_pkg::ST_MUL_K: if (udone) begin
        if (k_new > lim_r) begin
          if (k1_r != '0 && lim_r >= k0_r) st_nxt = bda_pkg::ST_DIV_T;
          else st_nxt = bda_pkg::ST_M1;
        end else if (r_r == '0) begin
          st_nxt = bda_pkg::ST_DONE;
        end else begin
          st_nxt = bda_pkg::ST_DIV;
        end
      end
      bda_pkg::ST_STEP:   st_nxt = bda_pkg::ST_DIV;
      bda_pkg::ST_DIV_T:  if (udone) st_nxt = bda_pkg::ST_MUL_TH;
      bda_pkg::ST_MUL_TH: if (udone) st_nxt = bda_pkg::ST_MUL_TK;
      bda_pkg::ST_MUL_TK: if (udone) st_nxt = bda_pkg::ST_M1;
      bda_pkg::ST_M1:     if (udone) st_nxt = bda_pkg::ST_M2;
      bda_pkg::ST_M2:     if (udone) st_nxt = bda_pkg::ST_M3;
      bda_pkg::ST_M3:     if (udone) st_nxt = bda_pkg::ST_M4;
      bda_pkg::ST_M4:     if (udone) st_nxt = bda_pkg::ST_M5;
      bda_pkg::ST_M5:     if (udone) st_nxt = bda_pkg::ST_M6;
      bda_pkg::ST_M6:     if (udone) st_nxt = bda_pkg::ST_CMP;
      bda_pkg::ST_CMP:    st_nxt = bda_pkg::ST_DONE;
      bda_pkg::ST_DONE:   st_nxt = bda_pkg::ST_IDLE;
      default:            st_nxt = bda_pkg::ST_IDLE;
    endcase
  end

  // Datapath and exits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= bda_pkg::ST_IDLE;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= (st_r == bda_pkg::ST_DONE);
      unique case (st_r)
        bda_pkg::ST_IDLE: if (accept) begin
          p_r <= p_in; q_r <= q_in; lim_r <= l_in;
          x_r <= p_in; y_r <= q_in;
          h0_r <= '0; h1_r <= W'(1); k0_r <= W'(1); k1_r <= '0;
          bad_r <= (q_in == '0);
          // target fits the bound: pass it through
          if (q_in != '0 && l_in != '0 && q_in <= l_in) begin
            rn_r <= p_in; rd_r <= q_in;
          end else begin
            rn_r <= '0; rd_r <= W'(1);
          end
        end
        bda_pkg::ST_DIV:   if (udone) begin a_r <= lo; r_r <= hi; end
        bda_pkg::ST_MUL_H: if (udone) h_r <= lo + h0_r;
        bda_pkg::ST_MUL_K: if (udone) begin
          x_r <= y_r; y_r <= r_r;
          if (k_new > lim_r) begin
            if (!(k1_r != '0 && lim_r >= k0_r)) begin
              t_r <= '0; ch_r <= h0_r; ck_r <= k0_r;
            end
          end else begin
            h0_r <= h1_r; h1_r <= h_r; k0_r <= k1_r; k1_r <= k_new;
            if (r_r == '0) begin
              rn_r <= h_r; rd_r <= k_new;
            end
          end
        end
        bda_pkg::ST_DIV_T:  if (udone) t_r <= lo;
        bda_pkg::ST_MUL_TH: if (udone) ch_r <= h0_r + lo;
        bda_pkg::ST_MUL_TK: if (udone) ck_r <= k0_r + lo;
        bda_pkg::ST_M1:     if (udone) m1_r <= lo;
        bda_pkg::ST_M2:     if (udone) m2_r <= lo;
        bda_pkg::ST_M3:     if (udone) begin ec_r <= dif; m1_r <= lo; end
        bda_pkg::ST_M4:     if (udone) m2_r <= lo;
        bda_pkg::ST_M5:     if (udone) begin ep_r <= dif; m1_r <= lo; c1h_r <= hi; end
        bda_pkg::ST_M6:     if (udone) begin m2_r <= lo; c1l_r <= hi; end
        bda_pkg::ST_CMP: begin
          // c1h holds high of ec*k1, c1l high of ep*ck
          if (c1h_r < c1l_r || (c1h_r == c1l_r && m1_r < m2_r)) begin
            rn_r <= ch_r; rd_r <= ck_r;
          end else begin
            rn_r <= h1_r; rd_r <= k1_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy          = (st_r != bda_pkg::ST_IDLE) || vld_r;
  assign out_valid     = vld_r;
  assign out_best_num  = rn_r[31:0];
  assign out_best_den  = rd_r[31:0];
  assign out_bad_input = bad_r;

  `ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMPL(a_bad_den, clk, rst_n, (out_valid && out_bad_input) |-> out_best_den == 32'd1)
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
endmodule

### sv/bda_unit.sv
// Shared iterative unit: restoring divide or shift-add multiply, one bit a cycle.
`include "assert_macros.svh"
module bda_unit #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  bda_pkg::op_t op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] res_lo,
  output logic [W-1:0] res_hi
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic          mul_r, mul_nxt;
  logic [W-1:0]  acc_r, acc_nxt, sh_r, sh_nxt, b_r, b_nxt;
  logic [W:0]    trial;
  logic [W:0]    msum;

  always_comb begin
    trial = {acc_r, sh_r[W-1]} - {1'b0, b_r};
    msum  = {1'b0, acc_r} + (sh_r[0] ? {1'b0, b_r} : '0);
  end

  // Sequencing of one operation
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mul_nxt  = mul_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    if (!busy_r && op != bda_pkg::OP_NONE) begin
      busy_nxt = 1'b1;
      mul_nxt  = (op == bda_pkg::OP_MUL);
      cnt_nxt  = CW'(W);
      acc_nxt  = '0;
      sh_nxt   = a;
      b_nxt    = b;
    end else if (busy_r) begin
      if (mul_r) begin
        // product high in acc, low shifts into sh
        acc_nxt = msum[W:1];
        sh_nxt  = {msum[0], sh_r[W-1:1]};
      end else if (!trial[W]) begin
        acc_nxt = trial[W-1:0];
        sh_nxt  = {sh_r[W-2:0], 1'b1};
      end else begin
        acc_nxt = {acc_r[W-2:0], sh_r[W-1]};
        sh_nxt  = {sh_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mul_r <= mul_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
  end

  // div: quotient low, remainder high; mul: low and high halves
  assign busy   = busy_r;
  assign done   = done_r;
  assign res_lo = sh_r;
  assign res_hi = acc_r;

  `ASSERT_NEXT(a_done_ends, clk, rst_n, done_r, !busy_r)
  `ASSERT_IMPL(a_cnt_live, clk, rst_n, busy_r |-> cnt_r != '0)
  `ASSERT_IMPL(a_no_both, clk, rst_n, !(done_r && busy_r))
endmodule

### dv/tb_top.sv
module tb_top;

  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int END_WAIT     = 300;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        bad;
  } frac_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_target_num = '0;
  logic [31:0] in_target_den = '0;
  logic [31:0] in_den_limit = '0;
  logic        out_valid;
  logic [31:0] out_best_num;
  logic [31:0] out_best_den;
  logic        out_bad_input;

  frac_t expected_fracs[$];
  int    err_count = 0;
  int    cycle_count = 0;

  bounded_denominator_approximation #(.WIDTH(32)) i_dut (
    .clk, .rst_n, .start, .busy,
    .in_target_num, .in_target_den, .in_den_limit,
    .out_valid, .out_best_num, .out_best_den, .out_bad_input
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Best approximation with denominator bound, continued-fraction walk
  function automatic frac_t approx_fraction(logic [31:0] p_in, logic [31:0] q_in,
                                            logic [31:0] lim_in);
    logic [63:0]  p, q, lim, x, y, a, r, h, k, h0, h1, k0, k1, t, ch, ck, ec, ep;
    logic [127:0] lhs, rhs;
    bit           done;
    frac_t        res;
    p = p_in; q = q_in; lim = lim_in;
    res = '{num: 32'd0, den: 32'd1, bad: 1'b0};
    done = 0;
    if (q == 0) begin
      res.bad = 1'b1;
    end else if (lim == 0) begin
      res.num = 0;
    end else if (q <= lim) begin
      res.num = p[31:0];
      res.den = q[31:0];
    end else begin
      h0 = 0; h1 = 1; k0 = 1; k1 = 0;
      x = p; y = q;
      while (y != 0 && !done) begin
        a = x / y;
        r = x % y;
        h = a * h1 + h0;
        k = a * k1 + k0;
        x = y; y = r;
        if (k > lim) begin
          // largest semiconvergent under the bound vs last convergent
          t = (k1 != 0 && lim >= k0) ? (lim - k0) / k1 : 0;
          ch = h0 + t * h1;
          ck = k0 + t * k1;
          ec = (ch * q >= ck * p) ? ch * q - ck * p : ck * p - ch * q;
          ep = (h1 * q >= k1 * p) ? h1 * q - k1 * p : k1 * p - h1 * q;
          lhs = 128'(ec) * 128'(k1);
          rhs = 128'(ep) * 128'(ck);
          if (lhs < rhs) begin
            res.num = ch[31:0]; res.den = ck[31:0];
          end else begin
            // ties keep the convergent
            res.num = h1[31:0]; res.den = k1[31:0];
          end
          done = 1;
        end else begin
          h0 = h1; h1 = h;
          k0 = k1; k1 = k;
        end
      end
      if (!done) begin
        res.num = h1[31:0];
        res.den = k1[31:0];
      end
    end
    return res;
  endfunction

  // Result check against oldest expectation
  always @(posedge clk) begin
    frac_t e;
    if (rst_n && out_valid) begin
      if (expected_fracs.size() == 0) begin
        $error("unexpected result %0d/%0d bad=%0d", out_best_num, out_best_den,
               out_bad_input);
        err_count++;
      end else begin
        e = expected_fracs.pop_front();
        if (out_best_num !== e.num) begin
          $error("best_num exp %0d got %0d", e.num, out_best_num);
          err_count++;
        end
        if (out_best_den !== e.den) begin
          $error("best_den exp %0d got %0d", e.den, out_best_den);
          err_count++;
        end
        if (out_bad_input !== e.bad) begin
          $error("bad_input exp %0d got %0d", e.bad, out_bad_input);
          err_count++;
        end
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // One transfer on the command port; called at a falling edge
  task automatic send_fraction(logic [31:0] p, logic [31:0] q, logic [31:0] lim,
                               int gap);
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    in_target_num = p;
    in_target_den = q;
    in_den_limit  = lim;
    start = 1'b1;
    @(posedge clk);
    expected_fracs.push_back(approx_fraction(p, q, lim));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_fracs.size() != 0) @(negedge clk);
  endtask

  // Operand spread: full range, random magnitude, tiny, near max
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 20);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 20);
    endcase
  endfunction

  task automatic test_special_cases();
    send_fraction(32'd7, 32'd0, 32'd100, 0);              // zero denominator
    send_fraction(32'hFFFF_FFFF, 32'd0, 32'd0, 0);
    send_fraction(32'd355, 32'd113, 32'd0, 0);            // zero bound
    send_fraction(32'd355, 32'd113, 32'd113, 0);          // fits the bound
    send_fraction(32'd6, 32'd4, 32'd10, 0);               // unreduced, fits
    send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_fraction(32'd0, 32'd1000, 32'd10, 0);            // zero numerator
    send_fraction(32'd600, 32'd400, 32'd1, 0);            // unreduced, over bound
    send_fraction(32'd1200, 32'd900, 32'd2, 1);
    send_fraction(32'd1, 32'd2, 32'd1, 0);                // equal distance
    send_fraction(32'd3, 32'd4, 32'd2, 0);
    send_fraction(32'd5, 32'd8, 32'd3, 0);
    send_fraction(32'd314159265, 32'd100000000, 32'd1000, 0);
    send_fraction(32'd2971215073, 32'd1836311903, 32'd1000000, 2);
    send_fraction(32'd1836311903, 32'd2971215073, 32'd1, 0);
    send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd5, 0);
    send_fraction(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);
    send_fraction(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 0);
    send_fraction(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5554, 0);
    send_fraction(32'h5555_5555, 32'hAAAA_AAAB, 32'hAAAA_AAAA, 0);
  endtask

  task automatic test_random_items(int n);
    logic [31:0] p, q, lim;
    for (int i = 0; i < n; i++) begin
      p   = rand_operand();
      q   = rand_operand();
      lim = ($urandom_range(0, 3) == 0) ? rand_operand() : $urandom_range(1, 5000);
      // keep a burst of back-to-back items now and then
      send_fraction(p, q, lim, (i % 40 < 8) ? 0 : pick_gap());
    end
  endtask

  task automatic test_drain_pause();
    test_random_items(10);
    wait_drained();
    test_random_items(10);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_special_cases();
    test_random_items(160);
    test_drain_pause();
    test_random_items(170);
    wait_drained();
    repeat (END_WAIT) @(negedge clk);
    if (err_count == 0 && expected_fracs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
